// ===== design/selt_pkg.sv =====
// Package for the shared/exclusive lock table: field widths, codes and the
// structs passed between the sequencer and the slot cells. No dependencies.
package selt_pkg;

  // Fixed field widths of the request and response beats.
  localparam int ACTION_W   = 2;
  localparam int HANDLE_W   = 5;
  localparam int EXT_KEY_W  = 32;
  localparam int STATUS_W   = 2;
  // Slot index width: covers up to 256 slots, though a 5-bit handle names at most 31.
  localparam int SLOT_IDX_W = 8;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ACQUIRE  = 2'd0,
    ACT_RELEASE  = 2'd1,
    ACT_VALIDATE = 2'd2,
    ACT_CHANGE   = 2'd3
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_IN_USE  = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    WR_NONE    = 2'd0,
    WR_ALLOC   = 2'd1,
    WR_RELEASE = 2'd2,
    WR_MODE    = 2'd3
  } wr_op_e;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_LOOKUP = 2'd1,
    S_SCAN   = 2'd2,
    S_DONE   = 2'd3
  } state_e;

  // Scan token that walks down the row of cells, one cell per cycle.
  typedef struct packed {
    logic                  active;
    action_e               action;
    logic                  excl;
    logic                  busy;
    logic                  free_found;
    logic [SLOT_IDX_W-1:0] free_idx;
    logic [SLOT_IDX_W-1:0] tgt_idx;
  } scan_tok_t;

  // Write-back command broadcast to all cells; the addressed one applies it.
  typedef struct packed {
    wr_op_e                op;
    logic [SLOT_IDX_W-1:0] idx;
    logic                  excl;
  } wr_cmd_t;

endpackage

// ===== design/selt_req_if.sv =====
// Request channel of the lock table: valid/ready handshake and request fields.
// Depends on selt_pkg for the field widths.
interface selt_req_if;
  import selt_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [ACTION_W-1:0]  action;
  logic [HANDLE_W-1:0]  handle;
  logic [EXT_KEY_W-1:0] object_key;
  logic                 access_mode;

  modport source (output valid, action, handle, object_key, access_mode, input ready);
  modport sink   (input valid, action, handle, object_key, access_mode, output ready);
endinterface

// ===== design/selt_rsp_if.sv =====
// Response channel of the lock table: valid/ready handshake and result fields.
// Depends on selt_pkg for the field widths.
interface selt_rsp_if;
  import selt_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [HANDLE_W-1:0]  new_handle;
  logic [EXT_KEY_W-1:0] found_key;

  modport source (output valid, status, new_handle, found_key, input ready);
  modport sink   (input valid, status, new_handle, found_key, output ready);
endinterface

// ===== design/selt_cell.sv =====
// One lock slot of the table: holds valid, key and mode, updates the passing
// scan token and applies write-back commands. Depends on selt_pkg.
module selt_cell #(
  parameter int KEY_BITS = 32,
  parameter int INDEX    = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  selt_pkg::scan_tok_t tok_in,
  input  logic [KEY_BITS-1:0] key_in,
  output selt_pkg::scan_tok_t tok_out,
  output logic [KEY_BITS-1:0] key_out,
  input  selt_pkg::wr_cmd_t   wr,
  input  logic [KEY_BITS-1:0] wr_key,
  output logic                slot_valid,
  output logic                slot_excl,
  output logic [KEY_BITS-1:0] slot_key
);
  import selt_pkg::*;

  localparam logic [SLOT_IDX_W-1:0] MyIdx = SLOT_IDX_W'(INDEX);

  scan_tok_t tok_next;
  logic      hit;
  logic      wr_here;

  assign hit     = slot_valid && (slot_key == key_in);
  assign wr_here = (wr.idx == MyIdx);

  // Fold this slot into the token's conflict and free-slot search.
  always_comb begin
    tok_next = tok_in;
    if (tok_in.active) begin
      case (tok_in.action)
        ACT_ACQUIRE: begin
          if (hit && (slot_excl || tok_in.excl)) tok_next.busy = 1'b1;
          if (!slot_valid && !tok_in.free_found) begin
            tok_next.free_found = 1'b1;
            tok_next.free_idx   = MyIdx;
          end
        end
        ACT_CHANGE: begin
          if (hit && (tok_in.tgt_idx != MyIdx)) tok_next.busy = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Token stage and slot valid bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out    <= '0;
      slot_valid <= 1'b0;
    end else begin
      tok_out <= tok_next;
      if (wr_here && wr.op == WR_ALLOC) begin
        slot_valid <= 1'b1;
      end else if (wr_here && wr.op == WR_RELEASE) begin
        slot_valid <= 1'b0;
      end
    end
  end

  // Key stage and slot contents.
  always_ff @(posedge clk) begin
    key_out <= key_in;
    if (wr_here && wr.op == WR_ALLOC) begin
      slot_key  <= wr_key;
      slot_excl <= wr.excl;
    end else if (wr_here && wr.op == WR_MODE) begin
      slot_excl <= wr.excl;
    end
  end

endmodule

// ===== design/shared_exclusive_lock_table_core.sv =====
// Top level of the shared/exclusive lock table: request sequencer, row of
// slot cells and response register. Depends on selt_pkg, selt_req_if,
// selt_rsp_if and selt_cell.
//
// A request passes from acceptance through the lookup state, which reads the
// addressed slot; the scan state, in which the scan token walks the row of
// cells checking keys and finding the lowest free slot and the token at the
// tail is registered to settle the outcome; and the done state, which loads
// the response and writes the slot back. Back in idle the next request is
// taken. One request is in flight at a time; a waiting response does not hold
// off the next request until its own result is ready. The slot valid bits
// clear at reset; root_key resets to zero and is written by cfg_wr_en.
module shared_exclusive_lock_table_core #(
  parameter int LOCK_SLOTS = 16,
  parameter int KEY_BITS   = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [selt_pkg::EXT_KEY_W-1:0] cfg_wr_data,
  selt_req_if.sink                       req,
  selt_rsp_if.source                     rsp
);
  import selt_pkg::*;

  state_e state, state_next;

  logic [EXT_KEY_W-1:0] root_key;

  // Captured request.
  action_e             req_action;
  logic [HANDLE_W-1:0] req_handle;
  logic [KEY_BITS-1:0] req_key;
  logic                req_excl;

  // Addressed slot, read in the lookup cycle.
  logic                sel_valid, sel_excl;
  logic [KEY_BITS-1:0] sel_key;
  logic                tgt_ok, tgt_excl;
  logic [KEY_BITS-1:0] tgt_key;

  // Chain links and cell state.
  scan_tok_t           tok_head;
  logic [KEY_BITS-1:0] key_head;
  scan_tok_t           tok_link [LOCK_SLOTS+1];
  logic [KEY_BITS-1:0] key_link [LOCK_SLOTS+1];
  logic [LOCK_SLOTS:0] link_active;
  logic                cell_valid [LOCK_SLOTS];
  logic                cell_excl  [LOCK_SLOTS];
  logic [KEY_BITS-1:0] cell_key   [LOCK_SLOTS];

  scan_tok_t fin;
  wr_cmd_t   wr;
  wr_op_e    res_op;
  status_e   res_status;
  logic [HANDLE_W-1:0]  res_handle;
  logic [EXT_KEY_W-1:0] res_key;

  logic inject, capture, out_load;

  logic                 out_valid;
  status_e              out_status;
  logic [HANDLE_W-1:0]  out_handle;
  logic [EXT_KEY_W-1:0] out_key;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      root_key <= '0;
    end else if (cfg_wr_en) begin
      root_key <= cfg_wr_data;
    end
  end

  // Next-state logic of the sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (req.valid) state_next = S_LOOKUP;
      S_LOOKUP: state_next = S_SCAN;
      S_SCAN:   if (tok_link[LOCK_SLOTS].active) state_next = S_DONE;
      S_DONE:   if (!out_valid || rsp.ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Output decode of the sequencer.
  always_comb begin
    req.ready = 1'b0;
    inject    = 1'b0;
    capture   = 1'b0;
    out_load  = 1'b0;
    unique case (state)
      S_IDLE:   req.ready = 1'b1;
      S_LOOKUP: inject = 1'b1;
      S_SCAN:   capture = tok_link[LOCK_SLOTS].active;
      S_DONE:   out_load = !out_valid || rsp.ready;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      req_action <= action_e'(req.action);
      req_handle <= req.handle;
      req_key    <= KEY_BITS'(req.object_key);
      req_excl   <= req.access_mode;
    end
  end

  // Read the slot named by the handle; null and out-of-range handles match none.
  always_comb begin
    sel_valid = 1'b0;
    sel_excl  = 1'b0;
    sel_key   = '0;
    for (int i = 0; i < LOCK_SLOTS; i++) begin
      if (int'(req_handle) == i + 1) begin
        sel_valid = cell_valid[i];
        sel_excl  = cell_excl[i];
        sel_key   = cell_key[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (inject) begin
      tgt_ok   <= sel_valid;
      tgt_excl <= sel_excl;
      tgt_key  <= sel_key;
    end
  end

  // Head of the chain: a fresh token is launched in the lookup cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_head <= '0;
    end else begin
      tok_head.active     <= inject;
      tok_head.action     <= req_action;
      tok_head.excl       <= req_excl;
      tok_head.busy       <= 1'b0;
      tok_head.free_found <= 1'b0;
      tok_head.free_idx   <= '0;
      tok_head.tgt_idx    <= SLOT_IDX_W'(req_handle) - SLOT_IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    key_head <= (req_action == ACT_CHANGE) ? sel_key : req_key;
  end

  assign tok_link[0] = tok_head;
  assign key_link[0] = key_head;

  // Row of slot cells.
  for (genvar g = 0; g < LOCK_SLOTS; g++) begin : g_cell
    selt_cell #(
      .KEY_BITS (KEY_BITS),
      .INDEX    (g)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .tok_in     (tok_link[g]),
      .key_in     (key_link[g]),
      .tok_out    (tok_link[g+1]),
      .key_out    (key_link[g+1]),
      .wr         (wr),
      .wr_key     (req_key),
      .slot_valid (cell_valid[g]),
      .slot_excl  (cell_excl[g]),
      .slot_key   (cell_key[g])
    );
  end

  for (genvar g = 0; g <= LOCK_SLOTS; g++) begin : g_active
    assign link_active[g] = tok_link[g].active;
  end

  // Token at the end of the row.
  always_ff @(posedge clk) begin
    if (capture) begin
      fin <= tok_link[LOCK_SLOTS];
    end
  end

  // Outcome of the request and the write-back it needs.
  always_comb begin
    res_status = ST_OK;
    res_handle = '0;
    res_key    = '0;
    res_op     = WR_NONE;
    unique case (req_action)
      ACT_ACQUIRE: begin
        if (fin.busy) begin
          res_status = ST_IN_USE;
        end else if (!fin.free_found) begin
          res_status = ST_FULL;
        end else begin
          res_op     = WR_ALLOC;
          res_handle = HANDLE_W'({1'b0, fin.free_idx} + (SLOT_IDX_W + 1)'(1));
        end
      end
      ACT_RELEASE: begin
        if (req_handle != '0) begin
          if (!tgt_ok) res_status = ST_INVALID;
          else         res_op = WR_RELEASE;
        end
      end
      ACT_VALIDATE: begin
        if (req_handle == '0)  res_key = root_key;
        else if (!tgt_ok)      res_status = ST_INVALID;
        else                   res_key = EXT_KEY_W'(tgt_key);
      end
      ACT_CHANGE: begin
        if (!tgt_ok)                             res_status = ST_INVALID;
        else if (req_excl && !tgt_excl && fin.busy) res_status = ST_IN_USE;
        else                                     res_op = WR_MODE;
      end
      default: ;
    endcase
  end

  // Write-back happens on the same edge the response is loaded.
  always_comb begin
    wr.op   = out_load ? res_op : WR_NONE;
    wr.idx  = (req_action == ACT_ACQUIRE) ? fin.free_idx : fin.tgt_idx;
    wr.excl = req_excl;
  end

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status <= res_status;
      out_handle <= res_handle;
      out_key    <= res_key;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.status     = out_status;
  assign rsp.new_handle = out_handle;
  assign rsp.found_key  = out_key;

  // At most one scan token is ever in the row.
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $countones(link_active) <= 1)
    else $error("more than one scan token in the cell row");

  // The tail of the row only carries a token while the sequencer waits for it.
  a_tail_in_scan: assert property (@(posedge clk) disable iff (rst)
    tok_link[LOCK_SLOTS].active |-> state == S_SCAN)
    else $error("scan token reached the tail outside the scan state");

  // Only a granted request can report a handle.
  a_handle_on_ok: assert property (@(posedge clk) disable iff (rst)
    out_load && res_status != ST_OK |=> rsp.new_handle == '0)
    else $error("handle reported for a failed request");

endmodule
